// File: hdl/rltd_pkg.sv
`timescale 1ns / 1ps

package rltd_pkg;

  localparam int DEF_STORE_DEPTH = 64;
  localparam int DEF_MAX_DIGITS  = 2;

  localparam int SYM_W   = 8;
  localparam int CFG_W   = 7;
  localparam int COUNT_W = 7;
  localparam int DIG_W   = 2;

  localparam logic [SYM_W-1:0]   ASCII_ZERO   = 8'd48;
  localparam logic [3:0]         RADIX        = 4'd10;
  localparam logic [CFG_W-1:0]   LENGTH_RESET = 7'd50;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic apply_count;
    logic accum_digit;
    logic single_byte;
    logic put_byte;
    logic clear_text;
    logic rd_first;
    logic rd_en;
    logic rd_next;
    logic load_flag;
    logic load_data;
  } rltd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic apply_needed;
    logic is_digit;
    logic run_active;
    logic last;
    logic too_long;
    logic empty;
    logic rd_last;
    logic out_free;
  } rltd_stat_t;

endpackage

// File: hdl/rltd_ctrl.sv
`timescale 1ns / 1ps

module rltd_ctrl
  import rltd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  rltd_stat_t stat,
  output rltd_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RUN,
    S_END,
    S_FLAG,
    S_READ,
    S_LOAD
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.apply_needed) begin
          cmd.apply_count = 1'b1;
          state_next      = S_RUN;
        end else if (stat.is_digit) begin
          cmd.accum_digit = 1'b1;
          state_next      = S_END;
        end else begin
          cmd.single_byte = 1'b1;
          state_next      = S_RUN;
        end
      end
      S_RUN: begin
        if (stat.run_active) begin
          cmd.put_byte = 1'b1;
        end else begin
          state_next = S_END;
        end
      end
      S_END: begin
        if (!stat.last) begin
          state_next = S_IDLE;
        end else if (stat.too_long || stat.empty) begin
          state_next = S_FLAG;
        end else begin
          cmd.rd_first = 1'b1;
          state_next   = S_READ;
        end
      end
      S_FLAG: begin
        if (stat.out_free) begin
          cmd.load_flag  = 1'b1;
          cmd.clear_text = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (stat.out_free) begin
          cmd.load_data = 1'b1;
          if (stat.rd_last) begin
            cmd.clear_text = 1'b1;
            state_next     = S_IDLE;
          end else begin
            cmd.rd_next = 1'b1;
            state_next  = S_READ;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/rltd_dp.sv
`timescale 1ns / 1ps

module rltd_dp
  import rltd_pkg::*;
#(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH,
  parameter int MAX_DIGITS  = DEF_MAX_DIGITS
) (
  input  logic             clk,
  input  logic             rst,
  input  rltd_cmd_t        cmd,
  output rltd_stat_t       stat,
  input  logic [SYM_W-1:0] in_symbol,
  input  logic             in_last,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [SYM_W-1:0] out_symbol,
  output logic             out_too_long,
  output logic             out_empty,
  output logic             out_last
);

  localparam int LEN_W  = $clog2(STORE_DEPTH + 2);
  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(STORE_DEPTH);
  localparam logic [LEN_W-1:0] LEN_SAT  = LEN_W'(STORE_DEPTH + 1);
  localparam logic [CFG_W-1:0] LIMIT_CAP = CFG_W'(STORE_DEPTH);
  localparam logic [DIG_W-1:0] DIG_MAX   = DIG_W'(MAX_DIGITS);

  logic [SYM_W-1:0]   sym;
  logic               last;
  logic [CFG_W-1:0]   max_length;
  logic [COUNT_W-1:0] pending_count;
  logic [DIG_W-1:0]   digits_seen;
  logic [COUNT_W-1:0] run_cnt;
  logic [LEN_W-1:0]   decoded_length;
  logic [ADDR_W-1:0]  rd_idx;
  logic [SYM_W-1:0]   rd_data;
  logic [SYM_W-1:0]   text_store [STORE_DEPTH];

  logic               is_digit;
  logic [SYM_W-1:0]   digit_val;
  logic [CFG_W-1:0]   limit;
  logic               too_long;
  logic               out_free;

  assign digit_val = sym - ASCII_ZERO;
  assign is_digit  = (sym >= ASCII_ZERO) && (sym < ASCII_ZERO + SYM_W'(RADIX));
  assign limit     = (max_length > LIMIT_CAP) ? LIMIT_CAP : max_length;
  assign too_long  = CFG_W'(decoded_length) > limit;
  assign out_free  = !out_valid || out_ready;

  assign stat.apply_needed = (digits_seen != '0) && ((digits_seen >= DIG_MAX) || !is_digit);
  assign stat.is_digit     = is_digit;
  assign stat.run_active   = (run_cnt != '0) && (decoded_length != LEN_SAT);
  assign stat.last         = last;
  assign stat.too_long     = too_long;
  assign stat.empty        = (decoded_length == '0);
  assign stat.rd_last      = (LEN_W'(rd_idx) + LEN_W'(1)) == decoded_length;
  assign stat.out_free     = out_free;

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sym  <= in_symbol;
      last <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= LENGTH_RESET;
    end else if (cfg_we) begin
      max_length <= cfg_wdata;
    end
  end

  // count gathering, run expansion and length
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count  <= '0;
      digits_seen    <= '0;
      run_cnt        <= '0;
      decoded_length <= '0;
    end else begin
      if (cmd.apply_count) begin
        run_cnt       <= pending_count;
        pending_count <= '0;
        digits_seen   <= '0;
      end else if (cmd.accum_digit) begin
        pending_count <= COUNT_W'(11'(pending_count) * 11'(RADIX) + 11'(digit_val));
        digits_seen   <= digits_seen + DIG_W'(1);
      end else if (cmd.single_byte) begin
        run_cnt <= COUNT_W'(1);
      end
      if (cmd.put_byte) begin
        run_cnt        <= run_cnt - COUNT_W'(1);
        decoded_length <= decoded_length + LEN_W'(1);
      end
      if (cmd.clear_text) begin
        pending_count  <= '0;
        digits_seen    <= '0;
        decoded_length <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put_byte && (decoded_length < LEN_FULL)) begin
      text_store[decoded_length[ADDR_W-1:0]] <= sym;
    end
    if (cmd.rd_en) begin
      rd_data <= text_store[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_first) begin
      rd_idx <= '0;
    end else if (cmd.rd_next) begin
      rd_idx <= rd_idx + ADDR_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_flag || cmd.load_data) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_flag) begin
      out_symbol   <= '0;
      out_too_long <= too_long;
      out_empty    <= !too_long;
      out_last     <= 1'b1;
    end else if (cmd.load_data) begin
      out_symbol   <= rd_data;
      out_too_long <= 1'b0;
      out_empty    <= 1'b0;
      out_last     <= stat.rd_last;
    end
  end

endmodule

// File: hdl/run_length_text_decoder.sv
`timescale 1ns / 1ps

// Run-length text decoder with decimal counts. Encoded bytes arrive one per
// request on the s_axis side, tlast on the final byte of a text. One or up to
// MAX_DIGITS ASCII digits form a count that repeats the next byte; any other
// byte is copied once, and a full count takes the next byte even if it is a
// digit. Decoded bytes go into an internal store of STORE_DEPTH bytes. After
// the final byte the m_axis side gives the text (tlast on its final byte), or
// a single too-long request when the length exceeds max_length (capped at
// STORE_DEPTH), or a single empty request. A count left dangling at the end
// is dropped. A count digit passes accept, decode and end; any other byte
// passes accept, decode, run and end, the run writing its decoded bytes (at
// most STORE_DEPTH+1, as the length saturates) one per cycle through the
// single store write port. After the final byte a flag result is loaded, or
// each emitted byte is read from the registered store and loaded once the
// output is free. The next text may start once the final result sits in the
// output register. max_length (reset 50) is written by cfg_we; the user must
// do so only while the block is idle, which the block does not enforce.

module run_length_text_decoder
  import rltd_pkg::*;
#(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH,
  parameter int MAX_DIGITS  = DEF_MAX_DIGITS
) (
  input  logic             clk,
  input  logic             rst,
  // input stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] symbol
  input  logic             s_axis_tlast,   // last
  // result stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] symbol_res
  output logic [1:0]       m_axis_tuser,   // [0] too_long, [1] empty_res
  output logic             m_axis_tlast,   // last_res
  // configuration
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata       // max_length
);

  rltd_cmd_t  cmd;
  rltd_stat_t stat;
  logic       too_long;
  logic       empty_res;

  // sequencing of decode, run expansion and read-out
  rltd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // count gathering, store, length and output register
  rltd_dp #(
    .STORE_DEPTH (STORE_DEPTH),
    .MAX_DIGITS  (MAX_DIGITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_symbol    (s_axis_tdata),
    .in_last      (s_axis_tlast),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_symbol   (m_axis_tdata),
    .out_too_long (too_long),
    .out_empty    (empty_res),
    .out_last     (m_axis_tlast)
  );

  assign m_axis_tuser = {empty_res, too_long};

endmodule

// File: verif/run_length_text_decoder_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the run-length text decoder. Encoded bytes go in on
// s_axis and decoded bytes come out on m_axis. Each accepted request is run
// through a behavioural decoder kept here, and the results it gives are queued.
// Every m_axis request is checked against the oldest entry in that queue.
module run_length_text_decoder_tb;
  import rltd_pkg::*;

  localparam int STORE_BYTES   = DEF_STORE_DEPTH;
  localparam int STALL_LIMIT   = 3000;  // cycles with no handshake on either side
  localparam int SETTLE_CYCLES = 8;     // quiet time once the last result is out
  localparam int HOLD_CYCLES   = 200;   // long m_axis hold-off, fills the block
  localparam int PHASE_ITEMS   = 27;    // random requests per max_length setting

  typedef struct packed {
    logic [7:0] sym;
    logic       too_long;
    logic       empty;
    logic       lst;
  } text_res_t;

  typedef struct {
    logic [7:0] sym;
    logic       lst;
    bit         typed;  // expectation written in the table, not predicted
    text_res_t  res;
  } stim_row_t;

  typedef enum int {TEXT_CLEAN, TEXT_NOISE, TEXT_DANGLING} text_style_t;

  localparam text_res_t NO_RES       = '{8'h00, 1'b0, 1'b0, 1'b0};
  localparam text_res_t EMPTY_RES    = '{8'h00, 1'b0, 1'b1, 1'b1};
  localparam text_res_t TOO_LONG_RES = '{8'h00, 1'b1, 1'b0, 1'b1};

  logic             clk;
  logic             rst           = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata  = 8'h00;
  logic             s_axis_tlast  = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [7:0]       m_axis_tdata;
  logic [1:0]       m_axis_tuser;
  logic             m_axis_tlast;
  logic             cfg_we        = 1'b0;
  logic [CFG_W-1:0] cfg_wdata     = '0;

  wire in_fire  = s_axis_tvalid && s_axis_tready;
  wire out_fire = m_axis_tvalid && m_axis_tready;

  // decoder state mirrored on the bench side
  logic [CFG_W-1:0]   length_limit = LENGTH_RESET;
  logic [COUNT_W-1:0] run_count    = '0;
  logic [DIG_W-1:0]   digits_got   = '0;
  logic [COUNT_W-1:0] text_len     = '0;
  logic [7:0]         text_bytes [STORE_BYTES];

  text_res_t expected_text_q [$];
  text_res_t fresh_res_q [$];
  int        mismatches   = 0;
  int        burst_left   = 0;
  int        phase_items  = 0;
  bit        hold_off_req = 1'b0;

  // Directed texts, run from reset with max_length at its reset value of 50.
  // Only the flag results are typed in; decoded bytes come from the predictor.
  stim_row_t directed [] = '{
    // lone digit: dangling count dropped, nothing decoded
    '{"5", 1'b1, 1'b1, EMPTY_RES},
    // plain byte copied once
    '{"x", 1'b1, 1'b0, NO_RES},
    // 99 repeats saturate the length, well past 50
    '{"9", 1'b0, 1'b0, NO_RES},
    '{"9", 1'b0, 1'b0, NO_RES},
    '{"A", 1'b1, 1'b1, TOO_LONG_RES},
    // zero count eats the Z, then the lowest byte is copied
    '{"0", 1'b0, 1'b0, NO_RES},
    '{"Z", 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b1, 1'b0, NO_RES},
    // full count: the third digit is the byte to repeat (12 times)
    '{"1", 1'b0, 1'b0, NO_RES},
    '{"2", 1'b0, 1'b0, NO_RES},
    '{"3", 1'b1, 1'b0, NO_RES},
    // highest byte
    '{8'hff, 1'b1, 1'b0, NO_RES},
    // zero count on the last byte leaves an empty text
    '{"0", 1'b0, 1'b0, NO_RES},
    '{"q", 1'b1, 1'b1, EMPTY_RES},
    // bytes either side of the digit range are not digits
    '{"4", 1'b0, 1'b0, NO_RES},
    '{"/", 1'b0, 1'b0, NO_RES},
    '{":", 1'b1, 1'b0, NO_RES},
    // text ends on a two-digit count that is dropped
    '{"2", 1'b0, 1'b0, NO_RES},
    '{8'h80, 1'b0, 1'b0, NO_RES},
    '{"3", 1'b0, 1'b0, NO_RES},
    '{"9", 1'b1, 1'b0, NO_RES}
  };

  // limits for the random phases: store size, zero, above the store, one,
  // then one drawn at random
  int phase_limits [5] = '{64, 0, 100, 1, 0};

  run_length_text_decoder u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // one decoded byte into the store; the length saturates one above its size
  task automatic store_byte(input logic [7:0] sym);
    if (text_len < STORE_BYTES) text_bytes[text_len] = sym;
    if (text_len < STORE_BYTES + 1) text_len++;
  endtask

  // Decode one accepted request; results it gives land in fresh_res_q.
  task automatic decode_byte(input logic [7:0] sym, input logic lst);
    bit        is_dig;
    int        acc;
    int        cap;
    text_res_t res;
    is_dig = (sym >= ASCII_ZERO) && (sym < ASCII_ZERO + RADIX);
    fresh_res_q.delete();
    if (digits_got > 0 && (digits_got >= DEF_MAX_DIGITS || !is_dig)) begin
      for (int c = 0; c < run_count; c++) store_byte(sym);
      run_count  = '0;
      digits_got = '0;
    end else if (is_dig) begin
      acc        = int'(run_count) * int'(RADIX) + int'(sym - ASCII_ZERO);
      run_count  = acc[COUNT_W-1:0];
      digits_got = digits_got + 1'b1;
    end else begin
      store_byte(sym);
    end
    if (lst) begin
      // a limit above the store acts as the store size
      cap = (length_limit > STORE_BYTES) ? STORE_BYTES : int'(length_limit);
      if (text_len > cap) begin
        fresh_res_q.push_back(TOO_LONG_RES);
      end else if (text_len == 0) begin
        fresh_res_q.push_back(EMPTY_RES);
      end else begin
        for (int i = 0; i < text_len; i++) begin
          res     = NO_RES;
          res.sym = text_bytes[i];
          res.lst = (i + 1 == text_len);
          fresh_res_q.push_back(res);
        end
      end
      run_count  = '0;
      digits_got = '0;
      text_len   = '0;
    end
  endtask

  // Offer one request. The sender runs in bursts; between bursts tvalid drops
  // for a random gap, sometimes none so that long unbroken stretches occur.
  task automatic send_request(input logic [7:0] sym, input logic lst, input bit typed,
                              input text_res_t typed_res);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sym;
    s_axis_tlast  <= lst;
    do @(posedge clk); while (!s_axis_tready);
    phase_items++;
    decode_byte(sym, lst);
    if (typed) expected_text_q.push_back(typed_res);
    else foreach (fresh_res_q[i]) expected_text_q.push_back(fresh_res_q[i]);
  endtask

  function automatic logic [7:0] rand_digit(input int hi);
    return ASCII_ZERO + 8'($urandom_range(0, hi));
  endfunction

  // One random text. Clean texts are runs and plain bytes; noise is digit-heavy
  // garbage; dangling texts end on a count with no byte after it.
  task automatic send_text(input text_style_t style);
    logic [7:0] enc_q [$];
    int         n_tok;
    n_tok = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 5);
    for (int t = 0; t < n_tok; t++) begin
      if (style == TEXT_NOISE) begin
        enc_q.push_back($urandom_range(0, 1) ? rand_digit(9) : 8'($urandom_range(0, 255)));
      end else begin
        case ($urandom_range(0, 4))
          0, 1: enc_q.push_back(8'($urandom_range(0, 255)));
          2, 3: begin
            enc_q.push_back(rand_digit(9));
            enc_q.push_back(8'($urandom_range(0, 255)));
          end
          default: begin
            // mostly short two-digit runs, now and then a long one
            enc_q.push_back(rand_digit(($urandom_range(0, 3) == 0) ? 9 : 2));
            enc_q.push_back(rand_digit(9));
            enc_q.push_back(8'($urandom_range(0, 255)));
          end
        endcase
      end
    end
    if (style == TEXT_DANGLING) begin
      enc_q.push_back(rand_digit(9));
      if ($urandom_range(0, 1)) enc_q.push_back(rand_digit(9));
    end
    foreach (enc_q[i]) send_request(enc_q[i], (i == enc_q.size() - 1), 1'b0, NO_RES);
  endtask

  // drop tvalid and wait until every expected result has been seen
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_text_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_length(input logic [CFG_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    length_limit  = value;
  endtask

  // stimulus
  initial begin : stimulus
    int pick;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[r]) begin
      send_request(directed[r].sym, directed[r].lst, directed[r].typed, directed[r].res);
    end

    phase_limits[4] = $urandom_range(0, 64);
    foreach (phase_limits[p]) begin
      write_max_length(CFG_W'(phase_limits[p]));
      // first random phase: stall the output while requests keep coming
      if (p == 0) hold_off_req = 1'b1;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        pick = $urandom_range(0, 19);
        if (pick < 14) send_text(TEXT_CLEAN);
        else if (pick < 17) send_text(TEXT_NOISE);
        else send_text(TEXT_DANGLING);
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("run_length_text_decoder regression: pass");
    end else begin
      $display("run_length_text_decoder regression: fail");
    end
    $finish;
  end

  // Result side: tready follows a randomly chosen mode - always ready, random,
  // or ready when a cycle counter is a multiple of four. A hold-off request
  // from the stimulus pulls it low for a long stretch.
  initial begin : result_sink
    int mode;
    int mode_left;
    int cyc;
    mode      = 0;
    mode_left = 0;
    cyc       = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_off_req) begin
        hold_off_req   = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(16, 80);
        end
        mode_left--;
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= (cyc % 4 == 0);
        endcase
      end
    end
  end

  // check each accepted result against the oldest expectation
  always @(posedge clk) begin : result_check
    text_res_t want;
    if (!rst && out_fire) begin
      if (expected_text_q.size() == 0) begin
        $error("unexpected result: tdata %0h tuser %0b tlast %0b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        mismatches++;
      end else begin
        want = expected_text_q.pop_front();
        if (m_axis_tdata !== want.sym) begin
          $error("symbol_res: expected %0h, got %0h", want.sym, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tuser[0] !== want.too_long) begin
          $error("too_long: expected %0b, got %0b", want.too_long, m_axis_tuser[0]);
          mismatches++;
        end
        if (m_axis_tuser[1] !== want.empty) begin
          $error("empty_res: expected %0b, got %0b", want.empty, m_axis_tuser[1]);
          mismatches++;
        end
        if (m_axis_tlast !== want.lst) begin
          $error("last_res: expected %0b, got %0b", want.lst, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  // watchdog: too long with no handshake on either side ends the run
  initial begin : watchdog
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if (rst || in_fire || out_fire) idle = 0;
      else idle++;
      if (idle >= STALL_LIMIT) begin
        $display("run_length_text_decoder regression: fail");
        $finish;
      end
    end
  end

endmodule
